FILE: hw/rtl/ring_stamp_cover_check_unit_macros.svh
// ----------------------------------------------------------------------------
// ring_stamp_cover_check_unit_macros: assertion macros for the ring check unit
// Clocked on clk; the plain form is masked while rst is high.
// ----------------------------------------------------------------------------
`ifndef RING_STAMP_COVER_CHECK_UNIT_MACROS_SVH
`define RING_STAMP_COVER_CHECK_UNIT_MACROS_SVH

// Property checked at every edge out of reset
`define RSCC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every edge, reset included
`define RSCC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/rscc_pkg.sv
// ----------------------------------------------------------------------------
// rscc_pkg: shared constants and types for the ring stamp cover check
// Frame limits, configuration register map, line memory word and the
// per-pixel position flags passed from the control logic to the core.
// ----------------------------------------------------------------------------
package rscc_pkg;

  // Frame limits
  localparam int MAX_COLS  = 1024;
  localparam int ROW_LIMIT = 1024;
  localparam int COL_W     = $clog2(MAX_COLS);
  localparam int ROW_W     = $clog2(ROW_LIMIT);

  // Configuration port
  localparam int CFG_W  = 11;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  // Register select (paddr bit 2)
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  // One line memory column: pixels of the two previous rows and the centre
  // flags of the two rows before the current centre row (shifted one column)
  typedef struct packed {
    logic p_old;
    logic p_new;
    logic c_old;
    logic c_new;
  } line_word_t;

  // Position of a pixel in the frame
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic             row_ge1;
    logic             row_ge2;
    logic             last_row;
    logic             col_zero;
    logic             col_ge2;
    logic             last_col;
  } pos_t;

endpackage

FILE: hw/rtl/rscc_if.sv
// ----------------------------------------------------------------------------
// rscc_if: stream channels of the ring stamp cover check
// Pixel channel in, result channel out; valid/ready handshake.
// ----------------------------------------------------------------------------
interface rscc_pixel_if;
  logic valid;
  logic ready;
  logic pixel_set;

  modport source (output valid, output pixel_set, input ready);
  modport sink (input valid, input pixel_set, output ready);
endinterface

interface rscc_result_if;
  logic valid;
  logic ready;
  logic image_reproducible;

  modport source (output valid, output image_reproducible, input ready);
  modport sink (input valid, input image_reproducible, output ready);
endinterface

FILE: hw/rtl/rscc_core.sv
// ----------------------------------------------------------------------------
// rscc_core: line memory, 3x3 windows and cover check
// Stage 0 reads the line memory column of the incoming pixel; stage 1
// builds the pixel and centre windows, finds the new centre, checks the
// pixels whose cover is final and writes the column back.
// ----------------------------------------------------------------------------
module rscc_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          restart,
  input  logic          take,
  input  logic          pixel_set,
  input  rscc_pkg::pos_t pos,
  output logic          res_valid,
  output logic          res_image
);
  import rscc_pkg::*;

  // Line memory, one word per column
  line_word_t line_mem [MAX_COLS];
  line_word_t rd_word;
  line_word_t wr_word;
  line_word_t fwd_word;
  line_word_t cur_word;
  logic       fwd_hit;

  // Stage 1 request
  logic s1_valid;
  logic s1_pixel;
  pos_t s1_pos;

  // Older two columns of each window row
  logic [1:0] p2w, p1w, p0w;
  logic [1:0] c3w, c2w, c1w;

  // Windows at the current column
  logic [2:0] p2, p1, p0;
  logic [4:0] c3, c2, c1;
  logic [1:0] p2h, p1h, p0h, c3h, c2h, c1h;
  logic       centre_new;
  logic       mismatch_now;
  logic       mismatch_seen;
  logic       frame_end;

  // Set pixel with no centre on its ring; q selects window column
  function automatic logic uncovered(input logic pix, input logic [4:0] lo,
                                     input logic [4:0] mid, input logic [4:0] hi,
                                     input int q);
    logic cov;
    cov = lo[q] | lo[q+1] | lo[q+2] | mid[q] | mid[q+2] | hi[q] | hi[q+1] | hi[q+2];
    return pix & ~cov;
  endfunction

  // Memory read and write ports
  always_ff @(posedge clk) begin
    if (take) begin
      rd_word <= line_mem[pos.col];
    end
    if (s1_valid) begin
      line_mem[s1_pos.col] <= wr_word;
    end
  end

  // Forward a write that lands on the column read in the same cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else begin
      fwd_hit <= take && s1_valid && (s1_pos.col == pos.col);
    end
  end

  always_ff @(posedge clk) begin
    fwd_word <= wr_word;
  end

  // Stage 1 register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_pixel <= pixel_set;
      s1_pos   <= pos;
    end
  end

  // Window assembly; rows above the frame read as empty
  always_comb begin
    cur_word = fwd_hit ? fwd_word : rd_word;
    if (!s1_pos.row_ge1) begin
      cur_word = '0;
    end
    p2h = s1_pos.col_zero ? 2'b00 : p2w;
    p1h = s1_pos.col_zero ? 2'b00 : p1w;
    p0h = s1_pos.col_zero ? 2'b00 : p0w;
    c3h = s1_pos.col_zero ? 2'b00 : c3w;
    c2h = s1_pos.col_zero ? 2'b00 : c2w;
    c1h = s1_pos.col_zero ? 2'b00 : c1w;
    p2 = {cur_word.p_old, p2h};
    p1 = {cur_word.p_new, p1h};
    p0 = {s1_pixel, p0h};
    centre_new = s1_pos.row_ge2 & s1_pos.col_ge2 & (&p2) & p1[0] & p1[2] & (&p0);
    c3 = {2'b00, cur_word.c_old, c3h};
    c2 = {2'b00, cur_word.c_new, c2h};
    c1 = {2'b00, centre_new, c1h};
  end

  // Cover check: two rows up always, the last two rows on the last row,
  // trailing columns at the end of a row
  always_comb begin
    mismatch_now = 1'b0;
    for (int q = 0; q < 3; q++) begin
      if (q == 0 || s1_pos.last_col) begin
        mismatch_now = mismatch_now | uncovered(p2[q], c3, c2, c1, q);
        if (s1_pos.last_row) begin
          mismatch_now = mismatch_now | uncovered(p1[q], c2, c1, 5'b00000, q)
                                      | uncovered(p0[q], c1, 5'b00000, 5'b00000, q);
        end
      end
    end
  end

  // Write-back word: rows move up by one
  always_comb begin
    wr_word.p_old = p1[2];
    wr_word.p_new = p0[2];
    wr_word.c_old = c2[2];
    wr_word.c_new = c1[2];
  end

  assign frame_end = s1_valid & s1_pos.last_row & s1_pos.last_col;
  assign res_valid = frame_end;
  assign res_image = ~(mismatch_seen | mismatch_now);

  // Window shift and frame mismatch flag
  always_ff @(posedge clk) begin
    if (rst) begin
      p2w <= '0;
      p1w <= '0;
      p0w <= '0;
      c3w <= '0;
      c2w <= '0;
      c1w <= '0;
      mismatch_seen <= 1'b0;
    end else begin
      if (s1_valid) begin
        p2w <= p2[2:1];
        p1w <= p1[2:1];
        p0w <= p0[2:1];
        c3w <= c3[2:1];
        c2w <= c2[2:1];
        c1w <= c1[2:1];
      end
      if (restart || frame_end) begin
        mismatch_seen <= 1'b0;
      end else if (s1_valid) begin
        mismatch_seen <= mismatch_seen | mismatch_now;
      end
    end
  end

endmodule

FILE: hw/rtl/ring_stamp_cover_check_unit.sv
// ----------------------------------------------------------------------------
// ring_stamp_cover_check_unit: ring opening check on a raster pixel stream
// Throughput one pixel per cycle while the result queue has room, the line memory
// read/modify/write taking one column a cycle. Frame flags pass stage 1 and the result queue.
// Sync reset clears counters, windows and result queue; line memory is not cleared.
// ----------------------------------------------------------------------------
module ring_stamp_cover_check_unit (
  input  logic                        clk,
  input  logic                        rst,
  rscc_pixel_if.sink                  pixel,
  rscc_result_if.source               result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rscc_pkg::ADDR_W-1:0] paddr,
  input  logic [rscc_pkg::DATA_W-1:0] pwdata,
  output logic [rscc_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import rscc_pkg::*;

  // Configuration registers
  logic [CFG_W-1:0] rows;
  logic [CFG_W-1:0] cols;
  logic             cfg_write;

  // Frame position
  logic [ROW_W-1:0] row_count;
  logic [COL_W-1:0] col_count;
  logic [ROW_W-1:0] rows_last;
  logic [COL_W-1:0] cols_last;
  pos_t             pos;
  logic             take;

  // Result queue, two entries
  logic [1:0] q_count;
  logic       q0, q1;
  logic       push, pop;
  logic       push_data;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      rows <= CFG_W'(3);
      cols <= CFG_W'(3);
    end else if (cfg_write) begin
      case (paddr[2])
        REG_ROWS: rows <= pwdata[CFG_W-1:0];
        REG_COLS: cols <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    case (paddr[2])
      REG_ROWS: prdata = {{(DATA_W-CFG_W){1'b0}}, rows};
      REG_COLS: prdata = {{(DATA_W-CFG_W){1'b0}}, cols};
      default:  prdata = '0;
    endcase
  end

  // Last row and column index; zero acts as one, oversize clamps
  always_comb begin
    if (rows == '0) begin
      rows_last = '0;
    end else if (32'(rows) > ROW_LIMIT) begin
      rows_last = ROW_W'(ROW_LIMIT - 1);
    end else begin
      rows_last = ROW_W'(rows - 1'b1);
    end
    if (cols == '0) begin
      cols_last = '0;
    end else if (32'(cols) > MAX_COLS) begin
      cols_last = COL_W'(MAX_COLS - 1);
    end else begin
      cols_last = COL_W'(cols - 1'b1);
    end
  end

  // Position flags of the incoming pixel
  always_comb begin
    pos.col      = col_count;
    pos.row_ge1  = (row_count != '0);
    pos.row_ge2  = (row_count >= ROW_W'(2));
    pos.last_row = (row_count == rows_last);
    pos.col_zero = (col_count == '0);
    pos.col_ge2  = (col_count >= COL_W'(2));
    pos.last_col = (col_count == cols_last);
  end

  assign take = pixel.valid & pixel.ready;

  // Raster counters; any register write restarts the frame
  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      row_count <= '0;
      col_count <= '0;
    end else if (take) begin
      if (pos.last_col) begin
        col_count <= '0;
        row_count <= pos.last_row ? '0 : row_count + 1'b1;
      end else begin
        col_count <= col_count + 1'b1;
      end
    end
  end

  rscc_core u_core (
    .clk       (clk),
    .rst       (rst),
    .restart   (cfg_write),
    .take      (take),
    .pixel_set (pixel.pixel_set),
    .pos       (pos),
    .res_valid (push),
    .res_image (push_data)
  );

  // Accept a request only if its result will find room in the queue
  assign pop = result.valid & result.ready;
  always_comb begin
    case (q_count)
      2'd0:    pixel.ready = 1'b1;
      2'd1:    pixel.ready = ~push | pop;
      2'd2:    pixel.ready = pop & ~push;
      default: pixel.ready = 1'b0;
    endcase
  end

  // Result queue occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      q_count <= '0;
    end else begin
      case ({push, pop})
        2'b10:   q_count <= q_count + 1'b1;
        2'b01:   q_count <= q_count - 1'b1;
        default: ;
      endcase
    end
  end

  // Result queue data
  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b10: begin
        if (q_count == 2'd0) begin
          q0 <= push_data;
        end else begin
          q1 <= push_data;
        end
      end
      2'b01: q0 <= q1;
      2'b11: begin
        if (q_count == 2'd1) begin
          q0 <= push_data;
        end else begin
          q0 <= q1;
          q1 <= push_data;
        end
      end
      default: ;
    endcase
  end

  assign result.valid              = (q_count != 2'd0);
  assign result.image_reproducible = q0;

endmodule

FILE: hw/rtl/rscc_checker.sv
// ----------------------------------------------------------------------------
// rscc_checker: port-level assertions for the ring stamp cover check
// Watches the pixel and result channels; bound to the top level below.
// ----------------------------------------------------------------------------
`include "ring_stamp_cover_check_unit_macros.svh"

module rscc_checker (
  input logic clk,
  input logic rst,
  input logic pix_valid,
  input logic pix_ready,
  input logic res_valid,
  input logic res_ready,
  input logic res_image
);

  // Queue is empty right after reset
  `RSCC_ASSERT_ALWAYS(a_empty_after_rst, rst |=> !res_valid, "result valid after reset")

  // A new result traces back to an earlier taken pixel request
  `RSCC_ASSERT(a_result_has_source, $rose(res_valid) |-> $past(pix_valid && pix_ready, 2), "result without a pixel request")

  // A stalled result stays offered
  `RSCC_ASSERT(a_result_held, res_valid && !res_ready |=> res_valid, "stalled result dropped")

  // A stalled result keeps its flag
  `RSCC_ASSERT(a_result_stable, res_valid && !res_ready |=> $stable(res_image), "stalled result changed")

endmodule

bind ring_stamp_cover_check_unit rscc_checker u_rscc_checker (
  .clk       (clk),
  .rst       (rst),
  .pix_valid (pixel.valid),
  .pix_ready (pixel.ready),
  .res_valid (result.valid),
  .res_ready (result.ready),
  .res_image (result.image_reproducible)
);

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for ring_stamp_cover_check_unit
// Streams binary frames in raster order, mostly built as unions of hollow 3x3
// stamps with some noise. An in-bench opening predictor computes the
// per-frame flag, and every result request is checked against it in order.
// Geometry is reprogrammed between phases over the APB port.
// ----------------------------------------------------------------------------
module tb;
  import rscc_pkg::*;

  typedef enum int {
    IMG_EMPTY,
    IMG_FULL,
    IMG_NOISE,
    IMG_STAMPS,
    IMG_STAMPS_FLIPPED
  } img_kind_e;

  localparam logic [ADDR_W-1:0] ROWS_ADDR = {REG_ROWS, 2'b00};
  localparam logic [ADDR_W-1:0] COLS_ADDR = {REG_COLS, 2'b00};
  localparam int SMALL_ITEMS   = 1400;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 8;
  localparam int BIG_PHASE     = 2;
  localparam int HOLD_PHASE    = 4;
  localparam int TINY_FRAMES   = 100;

  logic              clk = 1'b0;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  rscc_pixel_if  pix_if ();
  rscc_result_if res_if ();

  ring_stamp_cover_check_unit DUT (
    .clk     (clk),
    .rst     (rst),
    .pixel   (pix_if),
    .result  (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #2 clk = ~clk;

  // Bench state
  bit pixel_q[$];
  bit frame_flag_q[$];
  int errors = 0;
  bit pix_taken = 1'b0;
  int pix_gap = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit calm = 1'b0;
  bit hold_request = 1'b0;
  bit hold_started = 1'b0;
  int small_items = 0;

  // Opening predictor state
  logic [CFG_W-1:0] cfg_rows;
  logic [CFG_W-1:0] cfg_cols;
  bit               line_pix [3][MAX_COLS];
  bit               line_cov [3][MAX_COLS];
  int               cur_row;
  int               cur_col;
  bit               frame_bad;

  // Register value to working size: 0 acts as 1, large values clamp
  function automatic int effective_size(input logic [CFG_W-1:0] v, input int lim);
    int s;
    s = int'(v);
    if (s == 0) s = 1;
    if (s > lim) s = lim;
    return s;
  endfunction

  function automatic void frame_restart();
    cur_row   = 0;
    cur_col   = 0;
    frame_bad = 1'b0;
  endfunction

  // A set pixel that no centre covers breaks the opening
  function automatic void check_cover(input int r, input int c);
    if (line_pix[r % 3][c] && !line_cov[r % 3][c]) frame_bad = 1'b1;
  endfunction

  // Takes one pixel; returns 1 when the frame ends, with its flag
  function automatic bit opening_step(input bit px, output bit flag);
    int  nr;
    int  nc;
    int  i;
    int  j;
    bit  ring;
    flag = 1'b0;
    nr = effective_size(cfg_rows, ROW_LIMIT);
    nc = effective_size(cfg_cols, MAX_COLS);
    i = cur_row;
    j = cur_col;
    if (i >= nr || j >= nc) begin
      frame_restart();
      i = 0;
      j = 0;
    end
    line_pix[i % 3][j] = px;
    line_cov[i % 3][j] = 1'b0;

    // centre at (i-1, j-1): all 8 ring neighbours set
    if (i >= 2 && j >= 2) begin
      ring = 1'b1;
      for (int dr = 0; dr < 3; dr++)
        for (int dc = 0; dc < 3; dc++)
          if (!(dr == 1 && dc == 1) && !line_pix[(i - 2 + dr) % 3][j - 2 + dc]) ring = 1'b0;
      if (ring)
        for (int dr = 0; dr < 3; dr++)
          for (int dc = 0; dc < 3; dc++)
            if (!(dr == 1 && dc == 1)) line_cov[(i - 2 + dr) % 3][j - 2 + dc] = 1'b1;
    end

    // row i-2 is final once its right neighbours are in
    if (i >= 2) begin
      if (j >= 2) check_cover(i - 2, j - 2);
      if (j == nc - 1)
        for (int c = (j >= 1 ? j - 1 : 0); c <= j; c++) check_cover(i - 2, c);
    end

    if (j + 1 < nc) begin
      cur_col = j + 1;
      return 1'b0;
    end
    if (i + 1 < nr) begin
      cur_col = 0;
      cur_row = i + 1;
      return 1'b0;
    end

    // last pixel: flush the two open rows
    for (int c = 0; c < nc; c++) begin
      if (i >= 1) check_cover(i - 1, c);
      check_cover(i, c);
    end
    flag = !frame_bad;
    frame_restart();
    return 1'b1;
  endfunction

  // Pixel driver
  always @(negedge clk) begin
    if (!pix_if.valid || pix_taken) begin
      if (pix_gap > 0) begin
        pix_gap = pix_gap - 1;
        pix_if.valid     <= 1'b0;
        pix_if.pixel_set <= 1'($urandom_range(0, 1));
      end else if (pixel_q.size() > 0) begin
        pix_if.valid     <= 1'b1;
        pix_if.pixel_set <= pixel_q.pop_front();
        if (!calm && $urandom_range(0, 9) == 0) pix_gap = $urandom_range(1, 5);
      end else begin
        pix_if.valid     <= 1'b0;
        pix_if.pixel_set <= 1'($urandom_range(0, 1));
      end
    end
  end

  // Result ready driver: random stalls plus one long hold-off
  always @(negedge clk) begin
    if (hold_request && !hold_started) begin
      hold_started = 1'b1;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      res_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      res_if.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 4);
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  // Monitor: predict on pixel requests, then check result requests
  always @(posedge clk) begin : monitor
    bit flag;
    bit want;
    pix_taken <= !rst && pix_if.valid && pix_if.ready;
    if (!rst && pix_if.valid && pix_if.ready) begin
      if (opening_step(pix_if.pixel_set, flag)) frame_flag_q.push_back(flag);
    end
    if (!rst && res_if.valid && res_if.ready) begin
      if (frame_flag_q.size() == 0) begin
        $error("image_reproducible: no request expected, actual %0b",
               res_if.image_reproducible);
        errors++;
      end else begin
        want = frame_flag_q.pop_front();
        if (res_if.image_reproducible !== want) begin
          $error("image_reproducible: expected %0b actual %0b", want,
                 res_if.image_reproducible);
          errors++;
        end
      end
    end
  end

  task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [CFG_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= DATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Drain everything in flight, then let the pipeline settle
  task automatic wait_idle();
    @(posedge clk);
    while (pixel_q.size() != 0 || pix_if.valid || frame_flag_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_geometry(input logic [CFG_W-1:0] r, input logic [CFG_W-1:0] c);
    wait_idle();
    apply_write(ROWS_ADDR, r);
    apply_write(COLS_ADDR, c);
  endtask

  // Every write also restarts the frame in the predictor
  task automatic apply_write(input logic [ADDR_W-1:0] addr, input logic [CFG_W-1:0] value);
    apb_write(addr, value);
    if (addr == ROWS_ADDR) cfg_rows = value;
    else cfg_cols = value;
    frame_restart();
  endtask

  task automatic push_bits(input bit [15:0] bits, input int n);
    for (int i = n - 1; i >= 0; i--) pixel_q.push_back(bits[i]);
  endtask

  // One frame (or a cut-off prefix of one) at the working size
  task automatic push_frame(input int nr, input int nc, input bit partial);
    bit        img[];
    int        n;
    int        len;
    int        r;
    int        c;
    int        k;
    img_kind_e kind;
    n = nr * nc;
    img = new[n];
    k = $urandom_range(0, 9);
    kind = (k == 0) ? IMG_EMPTY : (k == 1) ? IMG_FULL : (k == 2) ? IMG_NOISE :
           (k < 7) ? IMG_STAMPS : IMG_STAMPS_FLIPPED;
    case (kind)
      IMG_FULL: begin
        foreach (img[i]) img[i] = 1'b1;
      end
      IMG_NOISE: begin
        foreach (img[i]) img[i] = 1'($urandom_range(0, 1));
      end
      IMG_STAMPS, IMG_STAMPS_FLIPPED: begin
        if (nr >= 3 && nc >= 3) begin
          repeat ($urandom_range(1, 1 + (nr - 2) * (nc - 2) / 3)) begin
            r = $urandom_range(1, nr - 2);
            c = $urandom_range(1, nc - 2);
            for (int dr = -1; dr <= 1; dr++)
              for (int dc = -1; dc <= 1; dc++)
                if (dr != 0 || dc != 0) img[(r + dr) * nc + c + dc] = 1'b1;
          end
        end
        // a stray or missing pixel usually breaks the match
        if (kind == IMG_STAMPS_FLIPPED) begin
          repeat ($urandom_range(1, 2)) begin
            k = $urandom_range(0, n - 1);
            img[k] = !img[k];
          end
        end
      end
      default: ;
    endcase
    len = n;
    if (partial && n > 1) len = $urandom_range(1, n - 1);
    for (int i = 0; i < len; i++) pixel_q.push_back(img[i]);
  endtask

  // Run limit
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Stimulus
  initial begin
    int phase;
    int r;
    int c;
    int nr;
    int nc;
    phase    = 0;

    rst              = 1'b1;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    pix_if.valid     = 1'b0;
    pix_if.pixel_set = 1'b0;
    res_if.ready     = 1'b0;
    cfg_rows         = CFG_W'(3);
    cfg_cols         = CFG_W'(3);
    frame_restart();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: reset geometry 3x3, full square then hollow ring
    push_bits(16'b111_111_111, 9);
    push_bits(16'b111_101_111, 9);
    // zero size acts as 1x1: set pixel fails, empty pixel passes
    set_geometry(CFG_W'(0), CFG_W'(0));
    push_bits(16'b10, 2);
    // cut a frame short; the next write restarts it
    set_geometry(CFG_W'(3), CFG_W'(3));
    push_bits(16'b111, 3);
    // single row: no centres, any set pixel fails
    set_geometry(CFG_W'(1), CFG_W'(3));
    push_bits(16'b010, 3);

    // Random phases, with one oversize frame and one long hold-off
    while (small_items < SMALL_ITEMS || phase <= HOLD_PHASE) begin
      if (phase == HOLD_PHASE) begin
        // tiny frames while the result side holds off
        set_geometry(CFG_W'(1), CFG_W'(1));
        hold_request = 1'b1;
        repeat (TINY_FRAMES) push_frame(1, 1, 1'b0);
        small_items += TINY_FRAMES;
      end else if (phase == BIG_PHASE) begin
        // one dimension above the limit, clamped
        if ($urandom_range(0, 1) == 0) set_geometry(CFG_W'(2047), CFG_W'(1));
        else set_geometry(CFG_W'(1), CFG_W'(2047));
        nr = effective_size(cfg_rows, ROW_LIMIT);
        nc = effective_size(cfg_cols, MAX_COLS);
        push_frame(nr, nc, 1'b0);
        small_items += nr * nc;
      end else begin
        r = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 20) : $urandom_range(0, 9);
        c = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 20) : $urandom_range(0, 9);
        set_geometry(CFG_W'(r), CFG_W'(c));
        nr = effective_size(cfg_rows, ROW_LIMIT);
        nc = effective_size(cfg_cols, MAX_COLS);
        repeat ($urandom_range(1, 4)) begin
          push_frame(nr, nc, 1'b0);
          small_items += nr * nc;
        end
        if ($urandom_range(0, 4) == 0) push_frame(nr, nc, 1'b1);
      end
      phase++;
    end

    // Closing stretch without idling
    set_geometry(CFG_W'(6), CFG_W'(7));
    calm = 1'b1;
    repeat (3) push_frame(6, 7, 1'b0);

    wait_idle();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
